@@ sv/fcm_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and the key hash for the flow counter block.
// No dependencies.
package fcm_pkg;

   localparam int FLOW_SLOTS = 256;
   localparam int SLOT_W     = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
   localparam int PROBE_W    = $clog2(FLOW_SLOTS + 1);

   localparam int ADDR_W     = 32;
   localparam int PORT_W     = 16;
   localparam int PROTO_W    = 8;
   localparam int COUNT_W    = 32;
   localparam int TOS_W      = 8;
   localparam int KEY_W      = 2 * ADDR_W + PROTO_W + 2 * PORT_W;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_THRESHOLD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MARK_TOS        = CSR_IDX_W'(1);

   localparam logic [PROTO_W-1:0] PROTO_TCP = PROTO_W'(6);
   localparam logic [PROTO_W-1:0] PROTO_UDP = PROTO_W'(17);

   localparam logic [COUNT_W-1:0] RESET_THRESHOLD = COUNT_W'(10);
   localparam logic [TOS_W-1:0]   RESET_MARK_TOS  = TOS_W'(8'h08);
   localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

   typedef logic [KEY_W-1:0] key_type;

   typedef struct packed {
      key_type              key;
      logic [COUNT_W-1:0]   count;
   } entry_type;

   // XOR-fold the key onto a slot index, then bring it below FLOW_SLOTS.
   // The folded value is below 2*FLOW_SLOTS, so one subtract suffices.
   function automatic logic [SLOT_W-1:0] key_hash(input key_type key);
      logic [SLOT_W-1:0] h;
      logic [SLOT_W:0]   wide;
      h = '0;
      for (int i = 0; i < KEY_W; i++) begin
         h[i % SLOT_W] = h[i % SLOT_W] ^ key[i];
      end
      wide = {1'b0, h};
      if (wide >= (SLOT_W + 1)'(FLOW_SLOTS)) begin
         wide = wide - (SLOT_W + 1)'(FLOW_SLOTS);
      end
      return wide[SLOT_W-1:0];
   endfunction

endpackage

@@ sv/flow_counter_threshold_marker.sv @@
`timescale 1ns / 1ps
// Per-flow packet counter with threshold marking; flow table in one RAM.
// Depends on fcm_pkg.
//
// Usage:
//   Input: a packet header transaction is taken at a rising edge where start
//   is high and busy is low. busy stays high until the result is issued.
//   Output: one result per transaction, shown for one cycle with rsp_valid.
//   The receiver cannot stall; results are never held.
//   Config: csr_ready is always high; a write lands when csr_valid is high.
//   Index 0 is count_threshold, index 1 mark_tos, others are dropped.
//   Write only while busy is low and no result is pending.
// Processing:
//   Header not ok: the result is registered straight from the accept, busy never rises.
//   Otherwise the flow RAM is probed by linear probing from a key hash; each
//   probe is a RAM read (ST_READ) plus a compare (ST_CHECK). A transaction
//   makes P probes (1 to FLOW_SLOTS); P is 1 for most flows while the table
//   is lightly loaded. No new transaction is taken until the result is issued.
//   The single RAM port and its registered read set the probe rate.
// Reset: synchronous; all slot valid bits are cleared at once, registers
//   return to threshold 10 and mark ToS 0x08. No clearing pass is needed.
module flow_counter_threshold_marker
   import fcm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  start,
   output logic                  busy,
   input  logic                  req_header_ok,
   input  logic [ADDR_W-1:0]     req_src_addr,
   input  logic [ADDR_W-1:0]     req_dst_addr,
   input  logic [PROTO_W-1:0]    req_protocol,
   input  logic                  req_l4_ok,
   input  logic [PORT_W-1:0]     req_src_port,
   input  logic [PORT_W-1:0]     req_dst_port,

   output logic                  rsp_valid,
   output logic                  rsp_mark_packet,
   output logic [TOS_W-1:0]      rsp_new_tos,
   output logic [COUNT_W-1:0]    rsp_flow_count,
   output logic                  rsp_flow_new,
   output logic                  rsp_table_full,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK
   } state_type;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   threshold_ff, threshold_in;
   logic [TOS_W-1:0]     mark_tos_ff, mark_tos_in;
   logic [FLOW_SLOTS-1:0] valid_ff, valid_in;
   key_type              key_ff, key_in;
   logic [SLOT_W-1:0]    idx_ff, idx_in;
   logic [PROBE_W-1:0]   probes_ff, probes_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_mark_ff, rsp_mark_in;
   logic [TOS_W-1:0]     rsp_tos_ff, rsp_tos_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_new_ff, rsp_new_in;
   logic                 rsp_full_ff, rsp_full_in;

   // flow table RAM
   entry_type            flow_mem [FLOW_SLOTS];
   entry_type            rd_data_ff;
   logic                 mem_we;
   entry_type            mem_wdata;

   logic                 use_ports;
   key_type              req_key;
   logic [COUNT_W-1:0]   count_inc;
   logic                 accept;

   assign accept    = start && (state_ff == ST_IDLE);
   assign use_ports = req_l4_ok && ((req_protocol == PROTO_TCP) || (req_protocol == PROTO_UDP));
   assign req_key   = {req_src_addr, req_dst_addr, req_protocol,
                       use_ports ? req_src_port : PORT_W'(0),
                       use_ports ? req_dst_port : PORT_W'(0)};
   assign count_inc = (rd_data_ff.count == COUNT_MAX) ? rd_data_ff.count
                                                      : rd_data_ff.count + COUNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      threshold_in = threshold_ff;
      mark_tos_in  = mark_tos_ff;
      valid_in     = valid_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      probes_in    = probes_ff;
      rsp_valid_in = 1'b0;
      rsp_mark_in  = 1'b0;
      rsp_tos_in   = '0;
      rsp_count_in = '0;
      rsp_new_in   = 1'b0;
      rsp_full_in  = 1'b0;
      mem_we       = 1'b0;
      mem_wdata    = '{key: key_ff, count: '0};

      if (csr_valid) begin
         case (csr_index)
            CSR_COUNT_THRESHOLD: threshold_in = csr_wdata[COUNT_W-1:0];
            CSR_MARK_TOS:        mark_tos_in  = csr_wdata[TOS_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_header_ok) begin
                  key_in    = req_key;
                  idx_in    = key_hash(req_key);
                  probes_in = '0;
                  state_in  = ST_READ;
               end else begin
                  // incomplete header: table untouched, all-zero result
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!valid_ff[idx_ff]) begin
               // empty slot ends the probe chain: new flow
               mem_we           = 1'b1;
               mem_wdata        = '{key: key_ff, count: '0};
               valid_in[idx_ff] = 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_new_in       = 1'b1;
               state_in         = ST_IDLE;
            end else if (rd_data_ff.key == key_ff) begin
               mem_wdata    = '{key: key_ff, count: count_inc};
               mem_we       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_count_in = count_inc;
               if (count_inc > threshold_ff) begin
                  rsp_mark_in = 1'b1;
                  rsp_tos_in  = mark_tos_ff;
               end
               state_in = ST_IDLE;
            end else begin
               probes_in = probes_ff + PROBE_W'(1);
               idx_in    = (idx_ff == SLOT_W'(FLOW_SLOTS - 1)) ? '0 : idx_ff + SLOT_W'(1);
               if (probes_in == PROBE_W'(FLOW_SLOTS)) begin
                  rsp_valid_in = 1'b1;
                  rsp_full_in  = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         threshold_ff <= RESET_THRESHOLD;
         mark_tos_ff  <= RESET_MARK_TOS;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         threshold_ff <= threshold_in;
         mark_tos_ff  <= mark_tos_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff       <= key_in;
      idx_ff       <= idx_in;
      probes_ff    <= probes_in;
      rsp_mark_ff  <= rsp_mark_in;
      rsp_tos_ff   <= rsp_tos_in;
      rsp_count_ff <= rsp_count_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_full_ff  <= rsp_full_in;
   end

   // single-port RAM; accesses of one transaction never overlap
   always_ff @(posedge clock) begin
      if (mem_we) begin
         flow_mem[idx_ff] <= mem_wdata;
      end
      rd_data_ff <= flow_mem[idx_ff];
   end

   assign busy            = (state_ff != ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mark_packet = rsp_mark_ff;
   assign rsp_new_tos     = rsp_tos_ff;
   assign rsp_flow_count  = rsp_count_ff;
   assign rsp_flow_new    = rsp_new_ff;
   assign rsp_table_full  = rsp_full_ff;

endmodule
